### hdl/tbp_pkg.sv
// Shared types and constants of the tuple bit packer.
// No dependencies; used by every module of the block.
package tbp_pkg;

    localparam int NUM_REGS           = 4;
    localparam int DATA_W             = 32;
    localparam int WIDTH_W            = 6;
    localparam int MAX_WIDTH          = 32;
    localparam int BYTE_W             = 8;
    localparam int OFFSET_W           = 12;
    localparam int APB_DATA_W         = 32;
    localparam int ADDR_W             = 4;
    localparam int SEL_W              = $clog2(NUM_REGS);
    localparam int IDX_W              = $clog2(NUM_REGS + 1);
    localparam int REMAIN_W           = $clog2(NUM_REGS * MAX_WIDTH + 1);
    localparam int ACC_W              = MAX_WIDTH + BYTE_W - 1;
    localparam int FILL_W             = $clog2(ACC_W + 1);
    localparam int FIELDS_DEFAULT     = 4;
    localparam int PAGE_BYTES_DEFAULT = 4096;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(8);

    // Register indexes (byte address / 4)
    localparam logic [SEL_W-1:0] REG_WIDTH_FIELD0 = SEL_W'(0);
    localparam logic [SEL_W-1:0] REG_WIDTH_FIELD1 = SEL_W'(1);
    localparam logic [SEL_W-1:0] REG_WIDTH_FIELD2 = SEL_W'(2);
    localparam logic [SEL_W-1:0] REG_WIDTH_FIELD3 = SEL_W'(3);

    // One classified tuple: masked values, saturated widths, and the number
    // of bits still to come from field j onward
    typedef struct packed {
        logic                               eop;
        logic [NUM_REGS-1:0][DATA_W-1:0]    value;
        logic [NUM_REGS-1:0][WIDTH_W-1:0]   width;
        logic [NUM_REGS-1:0][REMAIN_W-1:0]  remain;
    } tuple_entry_t;

endpackage

### hdl/tbp_front.sv
// Front end of the tuple bit packer: width registers, request intake and
// classification of each tuple. Depends on tbp_pkg.
module tbp_front #(
    parameter int FIELDS = tbp_pkg::FIELDS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbp_pkg::ADDR_W-1:0]       paddr,
    input  logic [tbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tbp_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tbp_pkg::DATA_W-1:0]       value0,
    input  logic [tbp_pkg::DATA_W-1:0]       value1,
    input  logic [tbp_pkg::DATA_W-1:0]       value2,
    input  logic [tbp_pkg::DATA_W-1:0]       value3,
    input  logic                             end_of_page,
    input  logic                             q_full,
    output logic                             push,
    output tbp_pkg::tuple_entry_t            entry
);
    import tbp_pkg::*;

    logic [WIDTH_W-1:0]                width_reg [NUM_REGS];
    logic [SEL_W-1:0]                  reg_sel;
    logic                              cfg_write;
    logic [NUM_REGS-1:0][DATA_W-1:0]   value_in;
    logic [REMAIN_W-1:0]               run_sum;
    logic [WIDTH_W-1:0]                w_sat;

    assign reg_sel   = paddr[SEL_W+1:2];
    assign cfg_write = psel && penable && pwrite;

    // Hold the field widths; ignore writes while not addressed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                width_reg[i] <= WIDTH_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_WIDTH_FIELD0: width_reg[0] <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_FIELD1: width_reg[1] <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_FIELD2: width_reg[2] <= pwdata[WIDTH_W-1:0];
                REG_WIDTH_FIELD3: width_reg[3] <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed width
    assign prdata = APB_DATA_W'(width_reg[reg_sel]);

    // Accept a request whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign value_in = {value3, value2, value1, value0};

    // Saturate widths, mask values, and build suffix sums of widths
    always_comb
    begin
        entry     = '0;
        entry.eop = end_of_page;
        run_sum   = '0;
        w_sat     = '0;
        for (int j = NUM_REGS - 1; j >= 0; j--)
        begin
            if (j >= FIELDS)
            begin
                w_sat = '0;
            end
            else if (width_reg[j] > WIDTH_W'(MAX_WIDTH))
            begin
                w_sat = WIDTH_W'(MAX_WIDTH);
            end
            else
            begin
                w_sat = width_reg[j];
            end
            entry.width[j]  = w_sat;
            entry.value[j]  = value_in[j] & ~({DATA_W{1'b1}} << w_sat);
            run_sum         = run_sum + REMAIN_W'(w_sat);
            entry.remain[j] = run_sum;
        end
    end

endmodule

### hdl/tbp_queue.sv
// Two-entry queue of classified tuples between front and back end.
// Depends on tbp_pkg.
module tbp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tbp_pkg::tuple_entry_t   push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output tbp_pkg::tuple_entry_t   head
);
    import tbp_pkg::*;

    tuple_entry_t  slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hdl/tbp_back.sv
// Back end of the tuple bit packer: bit accumulator, byte emission,
// page position and the output register. Depends on tbp_pkg.
module tbp_back #(
    parameter int FIELDS     = tbp_pkg::FIELDS_DEFAULT,
    parameter int PAGE_BYTES = tbp_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  tbp_pkg::tuple_entry_t          head,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tbp_pkg::BYTE_W-1:0]     out_byte,
    output logic [tbp_pkg::OFFSET_W-1:0]   byte_offset,
    output logic                           last_of_item
);
    import tbp_pkg::*;

    localparam int POS_W = $clog2(PAGE_BYTES);
    localparam int ACT   = (FIELDS < NUM_REGS) ? FIELDS : NUM_REGS;
    localparam logic [IDX_W-1:0] FIELD_COUNT = IDX_W'(ACT);
    localparam logic [FILL_W-1:0] BYTE_FILL  = FILL_W'(BYTE_W);

    logic [ACC_W-1:0]     acc_reg,  acc_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]     idx_reg,  idx_next;
    logic [POS_W-1:0]     pos_reg,  pos_next;
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;
    logic                 out_last_reg;

    logic [SEL_W-1:0]     sel;
    logic                 fields_left;
    logic [REMAIN_W-1:0]  rem;
    logic [REMAIN_W:0]    left_bits;
    logic                 slot_free;
    logic                 emit_full;
    logic                 absorb;
    logic                 pad;
    logic                 emit;
    logic                 last_full;
    logic [ACC_W-1:0]     shifted_down;
    logic [ACC_W-1:0]     shifted_up;
    logic [BYTE_W-1:0]    byte_val;

    assign sel         = idx_reg[SEL_W-1:0];
    assign fields_left = (idx_reg < FIELD_COUNT);
    assign rem         = fields_left ? head.remain[sel] : '0;
    assign slot_free   = !out_valid_reg || out_ready;

    // Classify the step: emit a full byte, take a field, or pad at page end
    assign emit_full = head_valid && (fill_reg >= BYTE_FILL) && slot_free;
    assign absorb    = head_valid && (fill_reg < BYTE_FILL) && fields_left;
    assign pad       = head_valid && (fill_reg < BYTE_FILL) && !fields_left
                       && head.eop && (fill_reg != '0) && slot_free;
    assign emit      = emit_full || pad;

    // A full byte is the last one when no full byte and no pad follows
    assign left_bits = (REMAIN_W+1)'(fill_reg - BYTE_FILL) + (REMAIN_W+1)'(rem);
    assign last_full = (left_bits < (REMAIN_W+1)'(BYTE_W))
                       && !(head.eop && (left_bits != '0));

    assign shifted_down = acc_reg >> (fill_reg - BYTE_FILL);
    assign shifted_up   = acc_reg << (BYTE_FILL - fill_reg);
    assign byte_val     = pad ? shifted_up[BYTE_W-1:0] : shifted_down[BYTE_W-1:0];

    // Advance the accumulator, field index and page position
    always_comb
    begin
        acc_next  = acc_reg;
        fill_next = fill_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        if (absorb)
        begin
            acc_next  = (acc_reg << head.width[sel]) | ACC_W'(head.value[sel]);
            fill_next = fill_reg + FILL_W'(head.width[sel]);
            idx_next  = idx_reg + IDX_W'(1);
        end
        if (emit)
        begin
            fill_next = emit_full ? (fill_reg - BYTE_FILL) : '0;
            pos_next  = (pos_reg == POS_W'(PAGE_BYTES - 1)) ? '0 : pos_reg + POS_W'(1);
        end
        pop = head_valid && (idx_next == FIELD_COUNT) && (fill_next < BYTE_FILL)
              && !(head.eop && (fill_next != '0));
        if (pop)
        begin
            idx_next = '0;
            if (head.eop)
            begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
            idx_reg  <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            pos_reg  <= pos_next;
        end
    end

    // Hold the emitted byte until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= byte_val;
            out_offset_reg <= OFFSET_W'(pos_reg);
            out_last_reg   <= pad || last_full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_offset  = out_offset_reg;
    assign last_of_item = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ACC_W))
        else $error("accumulator fill exceeds its width");

    a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (fill_reg < BYTE_FILL) && (idx_reg == '0))
        else $error("tuple retired with a full byte or fields left");

    a_eop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.eop) |=> (pos_reg == '0) && (fill_reg == '0))
        else $error("end of page did not restart the page");

    a_stall_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_byte_reg))
        else $error("pending byte lost while the receiver stalls");

endmodule

### hdl/tuple_bit_packer.sv
// Top level of the tuple bit packer: APB width registers, tuple intake,
// queue and byte emitter. Depends on tbp_pkg, tbp_front, tbp_queue, tbp_back.
//
// Usage:
//   Configure width_field0..3 over the APB port (byte addresses 0, 4, 8, 12)
//   while the block is idle; widths above 32 act as 32, zero drops the field.
//   Input requests (value0..3, end_of_page) enter on in_valid/in_ready; each
//   completed byte leaves on out_valid/out_ready with its page offset, and
//   last_of_item marks the final byte of a tuple. A tuple with no full byte
//   and no flush produces nothing.
//   A request is stored in the queue when accepted and reaches the emitter
//   from there; the emitter takes one field per cycle until a byte completes,
//   and each completed byte is registered before out_valid rises.
//   In each step the emitter either takes a field or emits a byte, never both,
//   so the fields and bytes of one tuple are handled one after another.
//   A two-entry queue lets new requests enter while bytes still drain.
//   Reset: widths return to 8, leftover bits and the page position clear.
//   When the receiver stalls, the pending byte holds, the emitter waits and
//   in_ready drops once the queue fills.
module tuple_bit_packer #(
    parameter int FIELDS     = tbp_pkg::FIELDS_DEFAULT,
    parameter int PAGE_BYTES = tbp_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tbp_pkg::ADDR_W-1:0]       paddr,
    input  logic [tbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tbp_pkg::DATA_W-1:0]       value0,
    input  logic [tbp_pkg::DATA_W-1:0]       value1,
    input  logic [tbp_pkg::DATA_W-1:0]       value2,
    input  logic [tbp_pkg::DATA_W-1:0]       value3,
    input  logic                             end_of_page,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tbp_pkg::BYTE_W-1:0]       out_byte,
    output logic [tbp_pkg::OFFSET_W-1:0]     byte_offset,
    output logic                             last_of_item
);
    import tbp_pkg::*;

    logic          q_full;
    logic          push;
    tuple_entry_t  push_entry;
    logic          pop;
    logic          head_valid;
    tuple_entry_t  head;

    assign pready = 1'b1;

    // Accept and classify requests
    tbp_front #(
        .FIELDS (FIELDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value0      (value0),
        .value1      (value1),
        .value2      (value2),
        .value3      (value3),
        .end_of_page (end_of_page),
        .q_full      (q_full),
        .push        (push),
        .entry       (push_entry)
    );

    // Decouple intake from emission
    tbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Pack bits and emit bytes
    tbp_back #(
        .FIELDS     (FIELDS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_offset  (byte_offset),
        .last_of_item (last_of_item)
    );

endmodule

### tb/tuple_bit_packer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for tuple_bit_packer: APB width writes, tuple requests in, bytes out.
// A scoreboard class predicts the packed byte stream and page offsets and checks each byte.
// Depends on tbp_pkg and the tuple_bit_packer RTL.

typedef struct packed {
    logic                                              eop;
    logic [tbp_pkg::NUM_REGS-1:0][tbp_pkg::DATA_W-1:0] value;
} tuple_req_t;

typedef struct packed {
    logic [tbp_pkg::BYTE_W-1:0]   data;
    logic [tbp_pkg::OFFSET_W-1:0] offset;
    logic                         last;
} packed_byte_t;

class packer_scoreboard;
    logic [tbp_pkg::WIDTH_W-1:0] width_cfg [tbp_pkg::NUM_REGS];
    logic [6:0]                  carry_bits;
    int                          carry_count;
    int                          page_pos;
    packed_byte_t                byte_q [$];
    int                          errors;

    function new();
        for (int i = 0; i < tbp_pkg::NUM_REGS; i++)
            width_cfg[i] = tbp_pkg::WIDTH_RESET;
        carry_bits  = '0;
        carry_count = 0;
        page_pos    = 0;
        errors      = 0;
    endfunction

    function void set_width(int idx, logic [tbp_pkg::WIDTH_W-1:0] w);
        width_cfg[idx] = w;
    endfunction

    function int pending();
        return byte_q.size();
    endfunction

    // Append the kept bits of each field, MSB first, and queue every completed byte
    function void note_tuple(tuple_req_t t);
        logic [63:0]                  acc;
        int                           fill;
        int                           w;
        logic [tbp_pkg::BYTE_W-1:0]   made [$];
        logic [tbp_pkg::OFFSET_W-1:0] offs [$];
        packed_byte_t                 b;
        acc  = {57'd0, carry_bits};
        fill = carry_count;
        for (int j = 0; j < tbp_pkg::FIELDS_DEFAULT; j++)
        begin
            w = (width_cfg[j] > tbp_pkg::MAX_WIDTH) ? tbp_pkg::MAX_WIDTH : int'(width_cfg[j]);
            if (w != 0)
            begin
                acc  = (acc << w) | (64'(t.value[j]) & ((64'd1 << w) - 64'd1));
                fill += w;
                while (fill >= 8)
                begin
                    made.insert(made.size(), 8'(acc >> (fill - 8)));
                    offs.insert(offs.size(), 12'(page_pos));
                    page_pos = (page_pos + 1) % tbp_pkg::PAGE_BYTES_DEFAULT;
                    fill -= 8;
                end
                acc &= (64'd1 << fill) - 64'd1;
            end
        end
        // Flush leftover bits padded with zeros, then restart the page
        if (t.eop)
        begin
            if (fill != 0)
            begin
                made.insert(made.size(), 8'(acc << (8 - fill)));
                offs.insert(offs.size(), 12'(page_pos));
            end
            acc      = '0;
            fill     = 0;
            page_pos = 0;
        end
        carry_bits  = acc[6:0];
        carry_count = fill;
        foreach (made[i])
        begin
            b.data   = made[i];
            b.offset = offs[i];
            b.last   = (i == made.size() - 1);
            byte_q.insert(byte_q.size(), b);
        end
    endfunction

    function void check_byte(logic [7:0] data, logic [11:0] offset, logic last);
        packed_byte_t exp_b;
        if (byte_q.size() == 0)
        begin
            $display("%0t: unexpected byte %h offset %0d last %b", $time, data, offset, last);
            errors++;
            return;
        end
        exp_b = byte_q.pop_front();
        if (data !== exp_b.data)
        begin
            $display("%0t: out_byte expected %h got %h", $time, exp_b.data, data);
            errors++;
        end
        if (offset !== exp_b.offset)
        begin
            $display("%0t: byte_offset expected %0d got %0d", $time, exp_b.offset, offset);
            errors++;
        end
        if (last !== exp_b.last)
        begin
            $display("%0t: last_of_item expected %b got %b", $time, exp_b.last, last);
            errors++;
        end
    endfunction
endclass

module tuple_bit_packer_test;
    import tbp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int LONG_PAGE_ITEMS = 264;
    localparam int SHORT_ITEMS     = 14;
    localparam int MAX_SEND_GAP    = 40;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_W-1:0]     paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [DATA_W-1:0]     value0       = '0;
    logic [DATA_W-1:0]     value1       = '0;
    logic [DATA_W-1:0]     value2       = '0;
    logic [DATA_W-1:0]     value3       = '0;
    logic                  end_of_page  = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [BYTE_W-1:0]     out_byte;
    logic [OFFSET_W-1:0]   byte_offset;
    logic                  last_of_item;

    packer_scoreboard sb;
    int accepted_items = 0;
    int send_idle_pct  = 17;
    int recv_idle_pct  = 86;
    int idle_cycles    = 0;

    tuple_bit_packer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value0       (value0),
        .value1       (value1),
        .value2       (value2),
        .value3       (value3),
        .end_of_page  (end_of_page),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_offset  (byte_offset),
        .last_of_item (last_of_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Check accepted bytes and stall the receiver at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_byte(out_byte, byte_offset, last_of_item);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Drop the run when no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tuple_bit_packer_test NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Setup and access cycle, then psel returns low so writes never overlap
    task automatic apb_write(input logic [SEL_W-1:0] idx, input logic [WIDTH_W-1:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= {($urandom_range(0, 1) ? 26'($urandom()) : 26'd0), w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_width(int'(idx), w);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_widths(input logic [WIDTH_W-1:0] w0, w1, w2, w3);
        apb_write(REG_WIDTH_FIELD0, w0);
        apb_write(REG_WIDTH_FIELD1, w1);
        apb_write(REG_WIDTH_FIELD2, w2);
        apb_write(REG_WIDTH_FIELD3, w3);
    endtask

    // Hold one request until accepted; shift the idling mix as the run advances
    task automatic send_tuple(input tuple_req_t t);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_SEND_GAP)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {value3, value2, value1, value0} <= t.value;
        end_of_page <= t.eop;
        do @(posedge clk); while (!in_ready);
        sb.note_tuple(t);
        accepted_items++;
        if (accepted_items == 120)
        begin
            send_idle_pct = 86;
            recv_idle_pct = 17;
        end
        else if (accepted_items == 240)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // Pause the sender until every byte has come, then let a tuple with no bytes finish
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic tuple_req_t make_tuple(logic [DATA_W-1:0] v0, v1, v2, v3, logic eop);
        tuple_req_t t;
        t.value = {v3, v2, v1, v0};
        t.eop   = eop;
        return t;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return WIDTH_W'(MAX_WIDTH);
            2:       return WIDTH_W'($urandom_range(MAX_WIDTH + 1, 63));
            default: return WIDTH_W'($urandom_range(1, MAX_WIDTH - 1));
        endcase
    endfunction

    function automatic tuple_req_t random_tuple(int eop_odds);
        return make_tuple(pick_value(), pick_value(), pick_value(), pick_value(),
                          eop_odds != 0 && $urandom_range(1, eop_odds) == 1);
    endfunction

    // Full-width phases run long enough without a page end to wrap the offset
    task automatic run_random_phase(input int items, input bit full_width);
        if (full_width)
            program_widths(WIDTH_W'($urandom_range(MAX_WIDTH, 63)),
                           WIDTH_W'($urandom_range(MAX_WIDTH, 63)),
                           WIDTH_W'($urandom_range(MAX_WIDTH, 63)),
                           WIDTH_W'($urandom_range(MAX_WIDTH, 63)));
        else
            program_widths(pick_width(), pick_width(), pick_width(), pick_width());
        repeat (items) send_tuple(random_tuple(full_width ? 0 : 6));
        wait_for_quiet();
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset widths of 8: byte-aligned tuples, page end with nothing left over
        send_tuple(make_tuple('0, '0, '0, '0, 1'b0));
        send_tuple(make_tuple('1, '1, '1, '1, 1'b0));
        send_tuple(make_tuple(32'h8000_0001, 32'h7FFF_FFFE, 32'hA5A5_5A5A, 32'h0000_00C3, 1'b1));
        send_tuple(make_tuple(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0));
        wait_for_quiet();

        // Zero widths drop every field: no bytes, with and without page end
        program_widths('0, '0, '0, '0);
        send_tuple(make_tuple('1, '1, '1, '1, 1'b0));
        send_tuple(make_tuple('1, '1, '1, '1, 1'b1));
        wait_for_quiet();

        // Widths above 32 saturate; a lone leftover bit carries over, two bits get flushed
        program_widths(6'd63, 6'd33, 6'd32, 6'd1);
        send_tuple(make_tuple('1, '1, '1, '1, 1'b0));
        send_tuple(make_tuple('0, '0, '0, '0, 1'b1));
        send_tuple(make_tuple(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, '1, 1'b0));
        send_tuple(make_tuple(32'hC3C3_C3C3, '0, '1, '0, 1'b1));
        wait_for_quiet();

        // Narrow fields: tuples with no full byte, carry across tuples, padded flush
        program_widths(6'd3, 6'd0, 6'd2, 6'd1);
        send_tuple(make_tuple('1, '1, '1, '1, 1'b0));
        send_tuple(make_tuple('1, '0, '1, '1, 1'b0));
        send_tuple(make_tuple(32'h5, '1, 32'h2, '0, 1'b0));
        send_tuple(make_tuple(32'h2, '0, 32'h1, '1, 1'b1));
        send_tuple(make_tuple('1, '1, '1, '1, 1'b1));
        wait_for_quiet();

        for (int p = 0; p < 3; p++)
            run_random_phase(SHORT_ITEMS, 1'b0);
        run_random_phase(LONG_PAGE_ITEMS, 1'b1);
        for (int p = 0; p < 4; p++)
            run_random_phase(SHORT_ITEMS, 1'b0);

        // Back to reset widths so the reset value is written too
        program_widths(WIDTH_RESET, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET);
        repeat (4) send_tuple(random_tuple(3));
        wait_for_quiet();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tuple_bit_packer_test OK");
        else
            $display("tuple_bit_packer_test NOT OK");
        $finish;
    end
endmodule
